@@ hw/rtl/fprm_pkg.sv @@
`default_nettype none

package fprm_pkg;

    // Field widths fixed by the item and register formats.
    localparam int unsigned NOW_W       = 32;
    localparam int unsigned ACTIVE_W    = 8;
    localparam int unsigned SECONDS_W   = 16;
    localparam int unsigned THRESHOLD_W = 10;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Default width of the probe and error counters.
    localparam int unsigned COUNT_WIDTH_DEFAULT = 24;

    // Scale of the error rate: errors are compared per thousand probes.
    localparam logic [THRESHOLD_W-1:0] PERMILLE_SCALE = 10'd1000;

    // Register reset values.
    localparam logic [SECONDS_W-1:0]   DOUBLE_FAIL_WINDOW_RST = 16'd60;
    localparam logic [SECONDS_W-1:0]   RECHECK_GAP_RST        = 16'd300;
    localparam logic [SECONDS_W-1:0]   SAMPLE_TIME_RST        = 16'd60;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST          = 10'd0;
    localparam logic                   CHECK_ENABLE_RST       = 1'b0;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOUBLE_FAIL_WINDOW = 3'd0,
        CFG_RECHECK_GAP        = 3'd1,
        CFG_SAMPLE_TIME        = 3'd2,
        CFG_THRESHOLD          = 3'd3,
        CFG_CHECK_ENABLE       = 3'd4
    } t_cfg_idx;

    // Event kinds of an input word.
    typedef enum logic [1:0] {
        KIND_FAIL  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_PROBE = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    // Outcome codes of a result word.
    typedef enum logic [2:0] {
        OUT_NONE    = 3'd0,
        OUT_PASSED  = 3'd1,
        OUT_FAILING = 3'd2,
        OUT_ORPHAN  = 3'd3,
        OUT_EARLY   = 3'd4
    } t_outcome;

endpackage

`default_nettype wire

@@ hw/rtl/fprm_if.sv @@
`default_nettype none

// Event channel: one word per path event.
interface fprm_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         kind;
    logic [fprm_pkg::NOW_W-1:0]         now_sec;
    logic                               probe_ok;
    logic [fprm_pkg::ACTIVE_W-1:0]      active_paths;
    logic                               already_down;

    modport source (output valid, kind, now_sec, probe_ok, active_paths, already_down,
                    input ready);
    modport sink   (input valid, kind, now_sec, probe_ok, active_paths, already_down,
                    output ready);
endinterface

// Result channel: one word per event.
interface fprm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] phase;
    logic       reinstate_blocked;
    logic       mark_failed;
    logic       hold_shaky;
    logic [2:0] outcome;

    modport source (output valid, phase, reinstate_blocked, mark_failed, hold_shaky,
                    outcome, input ready);
    modport sink   (input valid, phase, reinstate_blocked, mark_failed, hold_shaky,
                    outcome, output ready);
endinterface

// Configuration write channel.
interface fprm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [fprm_pkg::CFG_IDX_W-1:0]      wr_index;
    logic [fprm_pkg::CFG_DATA_W-1:0]     wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/flaky_path_error_rate_monitor_top.sv @@
// Flakiness monitor for one path.
// Channels: i_in carries event words (path failure, reinstate query, probe
// result, time tick), o_out returns exactly one result word per event, and
// i_cfg writes the five configuration registers by index. All three use a
// valid/ready handshake; a word moves at a clock edge with both high.
// Order: an event word is taken into the input register, and the result
// register is loaded from it when the result register is free or is being
// emptied in the same cycle.
// Throughput: one event per cycle while the receiver keeps taking results.
// The state update and the rate compare (two multiplies of at most
// COUNT_WIDTH by 10 bits) sit between the input register and the result
// register, and each event sees the state the previous one left.
// Reset (i_rst_n low at a clock edge) empties both registers, sets the
// phase to idle, clears the counters and times, and loads the register
// defaults. The configuration channel is always ready.
// When the receiver stalls, the result word holds; the input register still
// fills, and i_in.ready drops once both registers are occupied.
`default_nettype none

module flaky_path_error_rate_monitor_top #(
    parameter int unsigned COUNT_WIDTH = fprm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fprm_in_if.sink    i_in,
    fprm_out_if.source o_out,
    fprm_cfg_if.sink   i_cfg
);

    localparam int unsigned ProdW = COUNT_WIDTH + fprm_pkg::THRESHOLD_W;
    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ONE   = 2'd1,
        PH_WAIT  = 2'd2,
        PH_CHECK = 2'd3
    } t_phase;

    // Configuration registers.
    logic [fprm_pkg::SECONDS_W-1:0]   r_window;
    logic [fprm_pkg::SECONDS_W-1:0]   r_gap;
    logic [fprm_pkg::SECONDS_W-1:0]   r_sample_time;
    logic [fprm_pkg::THRESHOLD_W-1:0] r_threshold;
    logic                             r_check_en;

    // Input register.
    logic                            r_in_valid;
    fprm_pkg::t_kind                 r_kind;
    logic [fprm_pkg::NOW_W-1:0]      r_now;
    logic                            r_probe_ok;
    logic [fprm_pkg::ACTIVE_W-1:0]   r_active;
    logic                            r_down;

    // Path state.
    t_phase                     r_phase, n_phase;
    logic                       r_blocked, n_blocked;
    logic [fprm_pkg::NOW_W-1:0] r_win_start, n_win_start;
    logic [fprm_pkg::NOW_W-1:0] r_dis_since, n_dis_since;
    logic [fprm_pkg::NOW_W-1:0] r_samp_start, n_samp_start;
    logic [COUNT_WIDTH-1:0]     r_probes, n_probes;
    logic [COUNT_WIDTH-1:0]     r_errors, n_errors;

    // Result register.
    logic                 r_out_valid;
    t_phase               r_o_phase;
    logic                 r_o_blocked;
    logic                 r_o_mark, n_mark;
    logic                 r_o_shaky, n_shaky;
    fprm_pkg::t_outcome   r_o_outcome, n_outcome;

    logic                       advance;
    logic                       process;
    logic [fprm_pkg::NOW_W-1:0] el_win;
    logic [fprm_pkg::NOW_W-1:0] el_dis;
    logic [fprm_pkg::NOW_W-1:0] el_samp;
    logic [ProdW-1:0]           err_scaled;
    logic [ProdW-1:0]           allowed;
    logic                       rate_ok;

    // Handshakes: the input register moves on when the result register is
    // free or is being emptied in the same cycle.
    assign advance     = !r_out_valid || o_out.ready;
    assign process     = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= fprm_pkg::DOUBLE_FAIL_WINDOW_RST;
            r_gap         <= fprm_pkg::RECHECK_GAP_RST;
            r_sample_time <= fprm_pkg::SAMPLE_TIME_RST;
            r_threshold   <= fprm_pkg::THRESHOLD_RST;
            r_check_en    <= fprm_pkg::CHECK_ENABLE_RST;
        end else if (i_cfg.valid) begin
            case (fprm_pkg::t_cfg_idx'(i_cfg.wr_index))
                fprm_pkg::CFG_DOUBLE_FAIL_WINDOW: r_window      <= i_cfg.wr_data;
                fprm_pkg::CFG_RECHECK_GAP:        r_gap         <= i_cfg.wr_data;
                fprm_pkg::CFG_SAMPLE_TIME:        r_sample_time <= i_cfg.wr_data;
                fprm_pkg::CFG_THRESHOLD:
                    r_threshold <= i_cfg.wr_data[fprm_pkg::THRESHOLD_W-1:0];
                fprm_pkg::CFG_CHECK_ENABLE:       r_check_en    <= i_cfg.wr_data[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind     <= fprm_pkg::t_kind'(i_in.kind);
            r_now      <= i_in.now_sec;
            r_probe_ok <= i_in.probe_ok;
            r_active   <= i_in.active_paths;
            r_down     <= i_in.already_down;
        end
    end

    // Elapsed times, modulo 2^32.
    assign el_win  = r_now - r_win_start;
    assign el_dis  = r_now - r_dis_since;
    assign el_samp = r_now - r_samp_start;

    // Exact rate compare: errors * 1000 against threshold * probes.
    assign err_scaled = ProdW'(r_errors) * ProdW'(fprm_pkg::PERMILLE_SCALE);
    assign allowed    = ProdW'(r_threshold) * ProdW'(r_probes);
    assign rate_ok    = (r_probes == '0) || (err_scaled <= allowed);

    // Next state and result for the event in the input register.
    always_comb begin
        n_phase      = r_phase;
        n_blocked    = r_blocked;
        n_win_start  = r_win_start;
        n_dis_since  = r_dis_since;
        n_samp_start = r_samp_start;
        n_probes     = r_probes;
        n_errors     = r_errors;
        n_mark       = 1'b0;
        n_shaky      = 1'b0;
        n_outcome    = fprm_pkg::OUT_NONE;
        case (r_kind)
            fprm_pkg::KIND_FAIL: begin
                if (r_check_en && !r_blocked && (r_phase == PH_IDLE || r_phase == PH_ONE)) begin
                    if (r_phase == PH_IDLE) begin
                        n_phase     = PH_ONE;
                        n_win_start = r_now;
                    end else if (el_win > fprm_pkg::NOW_W'(r_window)) begin
                        // The window ran out: this failure opens a new one.
                        n_win_start = r_now;
                    end else begin
                        n_blocked   = 1'b1;
                        n_phase     = PH_WAIT;
                        n_dis_since = '0;
                        n_mark      = !r_down;
                    end
                end
            end
            fprm_pkg::KIND_QUERY: begin
                if (r_active == '0) begin
                    // No active path left in the group: recover at once.
                    n_phase   = PH_IDLE;
                    n_blocked = 1'b0;
                    n_outcome = fprm_pkg::OUT_EARLY;
                end else begin
                    n_shaky = 1'b1;
                    if (r_phase == PH_WAIT && el_dis > fprm_pkg::NOW_W'(r_gap)) begin
                        n_phase      = PH_CHECK;
                        n_samp_start = r_now;
                        n_probes     = '0;
                        n_errors     = '0;
                    end
                end
            end
            fprm_pkg::KIND_PROBE: begin
                if (r_phase == PH_CHECK) begin
                    if (r_probes != CountMax) begin
                        n_probes = r_probes + COUNT_WIDTH'(1);
                    end
                    if (!r_probe_ok && r_errors != CountMax) begin
                        n_errors = r_errors + COUNT_WIDTH'(1);
                    end
                end
            end
            fprm_pkg::KIND_TICK: begin
                if (r_phase == PH_CHECK && el_samp >= fprm_pkg::NOW_W'(r_sample_time)) begin
                    if (rate_ok) begin
                        n_phase   = PH_IDLE;
                        n_blocked = 1'b0;
                        n_outcome = fprm_pkg::OUT_PASSED;
                    end else if (r_active != '0) begin
                        n_phase     = PH_WAIT;
                        n_blocked   = 1'b1;
                        n_dis_since = r_now;
                        n_outcome   = fprm_pkg::OUT_FAILING;
                    end else begin
                        n_phase   = PH_IDLE;
                        n_blocked = 1'b0;
                        n_outcome = fprm_pkg::OUT_ORPHAN;
                    end
                end
            end
            default: ;
        endcase
    end

    // State and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_blocked    <= 1'b0;
            r_win_start  <= '0;
            r_dis_since  <= '0;
            r_samp_start <= '0;
            r_probes     <= '0;
            r_errors     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (process) begin
                r_phase      <= n_phase;
                r_blocked    <= n_blocked;
                r_win_start  <= n_win_start;
                r_dis_since  <= n_dis_since;
                r_samp_start <= n_samp_start;
                r_probes     <= n_probes;
                r_errors     <= n_errors;
                r_out_valid  <= 1'b1;
                r_o_phase    <= n_phase;
                r_o_blocked  <= n_blocked;
                r_o_mark     <= n_mark;
                r_o_shaky    <= n_shaky;
                r_o_outcome  <= n_outcome;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.phase             = r_o_phase;
    assign o_out.reinstate_blocked = r_o_blocked;
    assign o_out.mark_failed       = r_o_mark;
    assign o_out.hold_shaky        = r_o_shaky;
    assign o_out.outcome           = r_o_outcome;

    // Reinstating is blocked exactly while waiting or checking.
    a_blocked_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blocked == (r_phase == PH_WAIT || r_phase == PH_CHECK))
        else $error("blocked flag out of step with phase");

    // Errors never outnumber probes in a sampling period.
    a_err_le_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_errors <= r_probes)
        else $error("error count above probe count");

    // A forced-down result always leaves the path blocked and waiting.
    a_mark_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_mark |-> r_o_blocked && r_o_phase == PH_WAIT)
        else $error("mark_failed without entering the wait phase");

    // Recovery outcomes leave the path idle and unblocked.
    a_recover_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_o_outcome == fprm_pkg::OUT_PASSED ||
                        r_o_outcome == fprm_pkg::OUT_ORPHAN ||
                        r_o_outcome == fprm_pkg::OUT_EARLY)
        |-> !r_o_blocked && r_o_phase == PH_IDLE)
        else $error("recovery outcome without idle phase");

    // A held result's outcome and phase stay put while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_o_outcome)
                                         && $stable(r_o_phase))
        else $error("result word changed under stall");

endmodule

`default_nettype wire
